>>> hdl/rotation_matrix_to_quaternion_assert.svh
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_assert.svh
// assertion macros shared by the checker; clk and rst are taken from the scope
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// same-cycle implication
`define RMQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmq assertion failed");

// next-cycle implication
`define RMQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmq assertion failed");

`endif

>>> hdl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// request and response types and shared constants of the matrix to
// quaternion converter
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int COMP_W = 16;   // width of every matrix entry and component
  localparam int NUM_W  = 17;   // width of a sum or difference of two entries

  // which component carries the root
  typedef enum logic [1:0] {
    DOM_W = 2'd0,
    DOM_X = 2'd1,
    DOM_Y = 2'd2,
    DOM_Z = 2'd3
  } dom_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] m00;
    logic signed [COMP_W-1:0] m01;
    logic signed [COMP_W-1:0] m02;
    logic signed [COMP_W-1:0] m10;
    logic signed [COMP_W-1:0] m11;
    logic signed [COMP_W-1:0] m12;
    logic signed [COMP_W-1:0] m20;
    logic signed [COMP_W-1:0] m21;
    logic signed [COMP_W-1:0] m22;
  } req_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] qw;
    logic signed [COMP_W-1:0] qx;
    logic signed [COMP_W-1:0] qy;
    logic signed [COMP_W-1:0] qz;
    logic                     invalid;
  } rsp_t;

endpackage

>>> hdl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// rotation matrix to unit quaternion by the four-case method, fixed point
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | rmq_pkg::req_t, nine entries
//   rsp     | out       | rsp_valid/rsp_stall  | rmq_pkg::rsp_t, qw..qz, invalid
//
// one request per cycle while rsp is not stalled. the pipe has one setup stage,
// a root stage per root bit (FRAC_BITS + 10), 17 divider stages and one output
// stage. the root and divider pipelines set the depth.
// reset clears the valid bits only. a stall on a valid rsp holds the whole pipe
// and is passed to req_stall in the same cycle.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rmq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rmq_pkg::rsp_t rsp
);

  localparam int CW  = rmq_pkg::COMP_W;
  localparam int NW  = rmq_pkg::NUM_W;
  localparam int RW  = FRAC_BITS + 18;          // clamped radicand
  localparam int RS  = RW + 1;                  // signed radicand
  localparam int SQ_W = RW + FRAC_BITS + 2;     // root input, even
  localparam int SW  = SQ_W / 2;                // root width
  localparam int MW  = NW + FRAC_BITS;          // scaled numerator magnitude
  localparam int Q_W = CW;
  localparam int T1_W = 2 + 3 + 3 * NW;
  localparam int T2_W = 1 + 2 + 3 + (SW - 2);
  localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] NEG_MAX = {1'b1, {(CW-1){1'b0}}};

  logic en;

  // whole pipe moves unless the output is held
  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  // setup: case choice, radicand, numerator magnitudes
  logic signed [17:0]   trace;
  logic signed [RS-1:0] rad_s;
  logic signed [NW-1:0] num [3];
  rmq_pkg::dom_t        dom_c;

  assign trace = 18'(req.m00) + 18'(req.m11) + 18'(req.m22);

  always_comb begin
    if (trace > 18'sd0) begin
      dom_c  = rmq_pkg::DOM_W;
      rad_s  = (RS'(1) <<< FRAC_BITS) + RS'(trace);
      num[0] = NW'(req.m21) - NW'(req.m12);
      num[1] = NW'(req.m02) - NW'(req.m20);
      num[2] = NW'(req.m10) - NW'(req.m01);
    end else if (req.m00 > req.m11 && req.m00 > req.m22) begin
      dom_c  = rmq_pkg::DOM_X;
      rad_s  = (RS'(1) <<< FRAC_BITS) + RS'(req.m00) - RS'(req.m11) - RS'(req.m22);
      num[0] = NW'(req.m21) - NW'(req.m12);
      num[1] = NW'(req.m01) + NW'(req.m10);
      num[2] = NW'(req.m02) + NW'(req.m20);
    end else if (req.m11 > req.m22) begin
      dom_c  = rmq_pkg::DOM_Y;
      rad_s  = (RS'(1) <<< FRAC_BITS) + RS'(req.m11) - RS'(req.m00) - RS'(req.m22);
      num[0] = NW'(req.m02) - NW'(req.m20);
      num[1] = NW'(req.m01) + NW'(req.m10);
      num[2] = NW'(req.m12) + NW'(req.m21);
    end else begin
      dom_c  = rmq_pkg::DOM_Z;
      rad_s  = (RS'(1) <<< FRAC_BITS) + RS'(req.m22) - RS'(req.m00) - RS'(req.m11);
      num[0] = NW'(req.m10) - NW'(req.m01);
      num[1] = NW'(req.m02) + NW'(req.m20);
      num[2] = NW'(req.m12) + NW'(req.m21);
    end
  end

  logic                a_valid;
  logic [RW-1:0]       a_rad;
  rmq_pkg::dom_t       a_dom;
  logic [2:0]          a_neg;
  logic [2:0][NW-1:0]  a_abs;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dom <= dom_c;
      a_rad <= rad_s[RS-1] ? '0 : rad_s[RW-1:0];
      for (int l = 0; l < 3; l++) begin
        a_neg[l] <= num[l][NW-1];
        a_abs[l] <= num[l][NW-1] ? NW'(-num[l]) : NW'(num[l]);
      end
    end
  end

  // root: S = floor(sqrt(rad * 2^(FRAC_BITS+2)))
  logic             s_valid;
  logic [SW-1:0]    s_root;
  logic [T1_W-1:0]  s_tag;
  rmq_pkg::dom_t    s_dom;
  logic [2:0]       s_neg;
  logic [2:0][NW-1:0] s_abs;

  rmq_sqrt #(
    .IN_W  (SQ_W),
    .TAG_W (T1_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a_valid),
    .radicand  ({a_rad, (FRAC_BITS + 2)'(0)}),
    .tag_in    ({a_dom, a_neg, a_abs}),
    .out_valid (s_valid),
    .root      (s_root),
    .tag_out   (s_tag)
  );

  assign {s_dom, s_neg, s_abs} = s_tag;

  // divide the three numerators by S
  logic [2:0][MW-1:0]  s_mag;
  logic                d_valid;
  logic [2:0][Q_W-1:0] d_quo;
  logic [2:0]          d_ovf;
  logic [T2_W-1:0]     d_tag;
  logic                d_inv;
  rmq_pkg::dom_t       d_dom;
  logic [2:0]          d_neg;
  logic [SW-3:0]       d_root4;

  for (genvar l = 0; l < 3; l++) begin : g_mag
    assign s_mag[l] = {s_abs[l], FRAC_BITS'(0)};
  end

  rmq_div #(
    .MAG_W (MW),
    .DIV_W (SW),
    .Q_W   (Q_W),
    .LANES (3),
    .TAG_W (T2_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .mag       (s_mag),
    .divisor   (s_root),
    .tag_in    ({(s_root == '0), s_dom, s_neg, s_root[SW-1:2]}),
    .out_valid (d_valid),
    .quo       (d_quo),
    .ovf       (d_ovf),
    .tag_out   (d_tag)
  );

  assign {d_inv, d_dom, d_neg, d_root4} = d_tag;

  // saturate quotients and the dominant term
  logic [CW-1:0] lane [3];
  logic [CW-1:0] dval;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (d_neg[l]) begin
        lane[l] = (d_ovf[l] || d_quo[l] >= NEG_MAX) ? NEG_MAX : CW'(-d_quo[l]);
      end else begin
        lane[l] = (d_ovf[l] || d_quo[l] >= POS_MAX) ? POS_MAX : d_quo[l];
      end
    end
    dval = (d_root4 > (SW-2)'(POS_MAX)) ? POS_MAX : d_root4[CW-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.invalid <= d_inv;
      if (d_inv) begin
        rsp.qw <= '0;
        rsp.qx <= '0;
        rsp.qy <= '0;
        rsp.qz <= '0;
      end else begin
        unique case (d_dom)
          rmq_pkg::DOM_W: begin
            rsp.qw <= dval;    rsp.qx <= lane[0];
            rsp.qy <= lane[1]; rsp.qz <= lane[2];
          end
          rmq_pkg::DOM_X: begin
            rsp.qw <= lane[0]; rsp.qx <= dval;
            rsp.qy <= lane[1]; rsp.qz <= lane[2];
          end
          rmq_pkg::DOM_Y: begin
            rsp.qw <= lane[0]; rsp.qx <= lane[1];
            rsp.qy <= dval;    rsp.qz <= lane[2];
          end
          default: begin
            rsp.qw <= lane[0]; rsp.qx <= lane[1];
            rsp.qy <= lane[2]; rsp.qz <= dval;
          end
        endcase
      end
    end
  end

endmodule

>>> hdl/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// pipelined floor square root, one result bit per register stage
// ----------------------------------------------------------------------------
module rmq_sqrt #(
  parameter int IN_W  = 48,
  parameter int TAG_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     radicand,
  input  logic [TAG_W-1:0]    tag_in,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   root,
  output logic [TAG_W-1:0]    tag_out
);

  localparam int RW = IN_W / 2;

  logic [IN_W-1:0]  rem_q [RW+1];
  logic [RW-1:0]    res_q [RW+1];
  logic             v_q   [RW+1];
  logic [TAG_W-1:0] tag_q [RW+1];

  assign rem_q[0] = radicand;
  assign res_q[0] = '0;
  assign v_q[0]   = in_valid;
  assign tag_q[0] = tag_in;

  // one stage per result bit, most significant first
  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam int B = RW - 1 - i;
    logic [IN_W-1:0] trial;

    assign trial = (IN_W'(res_q[i]) << (B + 1)) | (IN_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i+1] <= 1'b0;
      end else if (en) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_q[i+1] <= tag_q[i];
        if (rem_q[i] >= trial) begin
          rem_q[i+1] <= rem_q[i] - trial;
          res_q[i+1] <= res_q[i] | (RW'(1) << B);
        end else begin
          rem_q[i+1] <= rem_q[i];
          res_q[i+1] <= res_q[i];
        end
      end
    end
  end

  assign out_valid = v_q[RW];
  assign root      = res_q[RW];
  assign tag_out   = tag_q[RW];

endmodule

>>> hdl/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// pipelined restoring divider, several lanes sharing one divisor; an overflow
// stage flags quotients that do not fit, then one quotient bit per stage
// ----------------------------------------------------------------------------
module rmq_div #(
  parameter int MAG_W = 31,
  parameter int DIV_W = 24,
  parameter int Q_W   = 16,
  parameter int LANES = 3,
  parameter int TAG_W = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][MAG_W-1:0] mag,
  input  logic [DIV_W-1:0]            divisor,
  input  logic [TAG_W-1:0]            tag_in,
  output logic                        out_valid,
  output logic [LANES-1:0][Q_W-1:0]   quo,
  output logic [LANES-1:0]            ovf,
  output logic [TAG_W-1:0]            tag_out
);

  localparam int CW = ((MAG_W > DIV_W + Q_W) ? MAG_W : DIV_W + Q_W) + 1;
  localparam int NS = Q_W + 2;

  logic [LANES-1:0][CW-1:0]  rem_q [NS];
  logic [LANES-1:0][Q_W-1:0] quo_q [NS];
  logic [LANES-1:0]          ovf_q [NS];
  logic [DIV_W-1:0]          dv_q  [NS];
  logic                      v_q   [NS];
  logic [TAG_W-1:0]          tag_q [NS];

  // stage 0 is the input
  for (genvar l = 0; l < LANES; l++) begin : g_in
    assign rem_q[0][l] = CW'(mag[l]);
  end
  assign quo_q[0] = '0;
  assign ovf_q[0] = '0;
  assign dv_q[0]  = divisor;
  assign v_q[0]   = in_valid;
  assign tag_q[0] = tag_in;

  // valid chain
  for (genvar s = 0; s < NS - 1; s++) begin : g_valid
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s+1] <= 1'b0;
      end else if (en) begin
        v_q[s+1] <= v_q[s];
      end
    end
  end

  // overflow check: quotient would reach 2^Q_W
  always_ff @(posedge clk) begin
    if (en) begin
      dv_q[1]  <= dv_q[0];
      tag_q[1] <= tag_q[0];
      quo_q[1] <= '0;
      rem_q[1] <= rem_q[0];
      for (int l = 0; l < LANES; l++) begin
        ovf_q[1][l] <= rem_q[0][l] >= (CW'(dv_q[0]) << Q_W);
      end
    end
  end

  // one quotient bit per stage
  for (genvar j = 0; j < Q_W; j++) begin : g_bit
    localparam int K = Q_W - 1 - j;
    logic [CW-1:0] shd;

    assign shd = CW'(dv_q[j+1]) << K;

    always_ff @(posedge clk) begin
      if (en) begin
        dv_q[j+2]  <= dv_q[j+1];
        tag_q[j+2] <= tag_q[j+1];
        ovf_q[j+2] <= ovf_q[j+1];
        for (int l = 0; l < LANES; l++) begin
          if (rem_q[j+1][l] >= shd) begin
            rem_q[j+2][l] <= rem_q[j+1][l] - shd;
            quo_q[j+2][l] <= quo_q[j+1][l] | (Q_W'(1) << K);
          end else begin
            rem_q[j+2][l] <= rem_q[j+1][l];
            quo_q[j+2][l] <= quo_q[j+1][l];
          end
        end
      end
    end
  end

  assign out_valid = v_q[NS-1];
  assign quo       = quo_q[NS-1];
  assign ovf       = ovf_q[NS-1];
  assign tag_out   = tag_q[NS-1];

endmodule

>>> hdl/rmq_checker.sv
// ----------------------------------------------------------------------------
// rmq_checker
// port-level checks of the converter, attached to the top level by bind
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_assert.svh"

module rmq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input rmq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input rmq_pkg::rsp_t rsp
);

  // a held response stays put
  `RMQ_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // requests are only held off by a stalled response
  `RMQ_ASSERT_IMP(a_stall_cause, req_stall, rsp_valid && rsp_stall)

  // a zero divisor clears every component
  `RMQ_ASSERT_IMP(a_inv_zero, rsp_valid && rsp.invalid,
    rsp.qw == 0 && rsp.qx == 0 && rsp.qy == 0 && rsp.qz == 0)

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);

>>> dv/rotation_matrix_to_quaternion_tb.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// checks the matrix to quaternion converter against a bit-exact predictor:
// directed corner matrices, then random rotations and raw noise, with random
// gaps on the request side and random stalls on the response side
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC     = 14;
  localparam int LATENCY  = FRAC + 29;
  localparam int MAX_IDLE = 17;
  localparam longint CYCLE_LIMIT = 200000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  rmq_pkg::req_t  req = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  rmq_pkg::rsp_t  rsp;

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rmq_pkg::req_t pending_mats[$];
  rmq_pkg::rsp_t expected_quats[$];
  int     mismatches = 0;
  int     sent = 0;
  int     received = 0;
  int     invalid_seen = 0;
  int     dom_seen[4] = '{0, 0, 0, 0};
  longint cycles = 0;

  // integer square root, bit by bit
  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // signed fixed-point quotient, truncated toward zero, clipped at 2^15
  function automatic longint fixed_quot(longint num, longint unsigned s);
    longint unsigned mag;
    longint unsigned q;
    mag = longint'(num < 0 ? -num : num) << FRAC;
    q = mag / s;
    if (q > 32768) q = 32768;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // expected quaternion of one matrix
  function automatic rmq_pkg::rsp_t quat_of(rmq_pkg::req_t m, output rmq_pkg::dom_t dom);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
    longint tr, rad, n0, n1, n2;
    longint q[4];
    longint nums[3];
    longint unsigned s;
    int k;
    rmq_pkg::rsp_t r;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      dom = rmq_pkg::DOM_W; rad = tr + (1 << FRAC);
      n0 = a21 - a12; n1 = a02 - a20; n2 = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      dom = rmq_pkg::DOM_X; rad = (1 << FRAC) + a00 - a11 - a22;
      n0 = a21 - a12; n1 = a01 + a10; n2 = a02 + a20;
    end else if (a11 > a22) begin
      dom = rmq_pkg::DOM_Y; rad = (1 << FRAC) + a11 - a00 - a22;
      n0 = a02 - a20; n1 = a01 + a10; n2 = a12 + a21;
    end else begin
      dom = rmq_pkg::DOM_Z; rad = (1 << FRAC) + a22 - a00 - a11;
      n0 = a10 - a01; n1 = a02 + a20; n2 = a12 + a21;
    end
    if (rad < 0) rad = 0;
    s = root64(longint'(rad) << (FRAC + 2));
    r = '0;
    if (s == 0) begin
      r.invalid = 1'b1;
      return r;
    end
    nums[0] = n0; nums[1] = n1; nums[2] = n2;
    k = 0;
    for (int i = 0; i < 4; i++) begin
      if (i == int'(dom)) begin
        q[i] = longint'(s >> 2);
      end else begin
        q[i] = fixed_quot(nums[k], s);
        k++;
      end
    end
    r.qw = clip16(q[0]); r.qx = clip16(q[1]);
    r.qy = clip16(q[2]); r.qz = clip16(q[3]);
    r.invalid = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch at response %0d: %s got %0d want %0d", received, what, got, want);
  endtask

  // diagonal-ish matrix helper
  function automatic rmq_pkg::req_t mat(int d0, int d1, int d2, int o01, int o02, int o10,
                                        int o12, int o20, int o21);
    rmq_pkg::req_t m;
    m.m00 = 16'(d0); m.m11 = 16'(d1); m.m22 = 16'(d2);
    m.m01 = 16'(o01); m.m02 = 16'(o02); m.m10 = 16'(o10);
    m.m12 = 16'(o12); m.m20 = 16'(o20); m.m21 = 16'(o21);
    return m;
  endfunction

  // random rotation built from a random unit-ish quaternion
  function automatic rmq_pkg::req_t random_rotation();
    real w, x, y, z, n;
    real e[9];
    rmq_pkg::req_t m;
    w = $urandom_range(0, 2000) - 1000.0; x = $urandom_range(0, 2000) - 1000.0;
    y = $urandom_range(0, 2000) - 1000.0; z = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(w*w + x*x + y*y + z*z);
    if (n < 1.0) begin
      w = 1.0; n = 1.0;
    end
    w /= n; x /= n; y /= n; z /= n;
    e[0] = 1 - 2*(y*y + z*z); e[1] = 2*(x*y - z*w); e[2] = 2*(x*z + y*w);
    e[3] = 2*(x*y + z*w); e[4] = 1 - 2*(x*x + z*z); e[5] = 2*(y*z - x*w);
    e[6] = 2*(x*z - y*w); e[7] = 2*(y*z + x*w); e[8] = 1 - 2*(x*x + y*y);
    for (int i = 0; i < 9; i++)
      e[i] = e[i] * 16384.0 + ($urandom_range(0, 8) - 4.0);
    m = mat(int'(e[0]), int'(e[4]), int'(e[8]), int'(e[1]), int'(e[2]), int'(e[3]),
            int'(e[5]), int'(e[6]), int'(e[7]));
    return m;
  endfunction

  // stimulus
  initial begin
    rmq_pkg::req_t m;
    // directed: identity, half-turns, extremes, negative-trace and zero matrices
    pending_mats.push_back(mat(16384, 16384, 16384, 0, 0, 0, 0, 0, 0));
    pending_mats.push_back(mat(16384, -16384, -16384, 0, 0, 0, 0, 0, 0));
    pending_mats.push_back(mat(-16384, 16384, -16384, 0, 0, 0, 0, 0, 0));
    pending_mats.push_back(mat(-16384, -16384, 16384, 0, 0, 0, 0, 0, 0));
    pending_mats.push_back(mat(0, 16384, 0, 0, 16384, 0, 0, -16384, 0));
    pending_mats.push_back(mat(32767, 32767, 32767, 32767, -32768, -32768,
                               32767, 32767, -32768));
    pending_mats.push_back(mat(-32768, -32768, -32768, 32767, 32767, 32767,
                               32767, 32767, 32767));
    pending_mats.push_back(mat(-32768, -32768, -32768, -32768, -32768, -32768,
                               -32768, -32768, -32768));
    pending_mats.push_back(mat(-32768, -32768, 32767, 32767, -32768, 32767,
                               -32768, 32767, -32768));
    pending_mats.push_back(mat(32767, -32768, -32768, 0, 0, 0, 0, 0, 0));
    pending_mats.push_back(mat(-16384, -16384, -16384, 100, 200, 300, 400, 500, 600));
    pending_mats.push_back(mat(0, 0, -16384, 0, 0, 0, 0, 0, 0));
    pending_mats.push_back(mat(0, 0, 0, 5, 7, 11, 13, 17, 19));
    pending_mats.push_back(mat(1, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_mats.push_back(mat(-20000, -20000, -8192, 1, -1, 2, -2, 3, -3));
    pending_mats.push_back(mat(-8192, -20000, -20000, 32767, 32767, 32767,
                               32767, 32767, 32767));
    pending_mats.push_back(mat(-20000, -8192, -20000, -32768, -32768, -32768,
                               -32768, -32768, -32768));
    pending_mats.push_back(mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
    // random: mostly rotations, some raw noise
    for (int i = 0; i < 500; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        m = random_rotation();
      end else begin
        m = rmq_pkg::req_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        if ($urandom_range(0, 3) == 0) m.m22 = 16'(-32768 + int'($urandom_range(0, 200)));
      end
      pending_mats.push_back(m);
    end
  end

  // request driver: gap is the idle cycles drawn before the next request
  int gap = 0;
  always @(posedge clk) begin
    rmq_pkg::dom_t d;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        sent++;
        gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, MAX_IDLE)) : 0;
      end else if (!req_valid && gap > 0) begin
        gap--;
      end
      // the slot is free once the current request is gone
      if (!req_valid || !req_stall) begin
        if (gap == 0 && pending_mats.size() > 0) begin
          req_valid <= 1'b1;
          req <= pending_mats[0];
          expected_quats.push_back(quat_of(pending_mats[0], d));
          dom_seen[int'(d)]++;
          void'(pending_mats.pop_front());
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and stall generator: hold is the stall drawn per response
  int hold = 0;
  always @(posedge clk) begin
    rmq_pkg::rsp_t want;
    cycles++;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_quats.size() == 0) begin
          report_mismatch("unexpected response", 0, 0);
        end else begin
          want = expected_quats.pop_front();
          if (rsp.qw !== want.qw) report_mismatch("qw", rsp.qw, want.qw);
          if (rsp.qx !== want.qx) report_mismatch("qx", rsp.qx, want.qx);
          if (rsp.qy !== want.qy) report_mismatch("qy", rsp.qy, want.qy);
          if (rsp.qz !== want.qz) report_mismatch("qz", rsp.qz, want.qz);
          if (rsp.invalid !== want.invalid)
            report_mismatch("invalid", rsp.invalid, want.invalid);
          if (want.invalid) invalid_seen++;
        end
        received++;
        hold = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, MAX_IDLE)) : 0;
      end else if (hold > 0) begin
        hold--;
      end
      rsp_stall <= (hold > 0);
    end
  end

  // reset, end of run, timeout
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while ((pending_mats.size() > 0 || req_valid || expected_quats.size() > 0)
           && cycles < CYCLE_LIMIT)
      @(posedge clk);
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d responses outstanding", expected_quats.size());
      $display("Verification failed");
      $finish;
    end else begin
      repeat (2 * LATENCY) @(posedge clk);
      $display("covered %0d matrices, %0d responses, %0d flagged invalid", sent,
               received, invalid_seen);
      $display("dominant component counts w/x/y/z: %0d/%0d/%0d/%0d", dom_seen[0],
               dom_seen[1], dom_seen[2], dom_seen[3]);
      if (mismatches == 0 && expected_quats.size() == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
      $finish;
    end
  end
endmodule

>>> filelist.f
+incdir+hdl
hdl/rmq_pkg.sv
hdl/rmq_sqrt.sv
hdl/rmq_div.sv
hdl/rotation_matrix_to_quaternion.sv
hdl/rmq_checker.sv
dv/rotation_matrix_to_quaternion_tb.sv
